### rtl/core/key_sort_engine_assert.svh
// Assertion macros for the key sort engine.
`ifndef KEY_SORT_ENGINE_ASSERT_SVH
`define KEY_SORT_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define KSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KSE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define KSE_ASSERT(lbl, prop, msg)
`define KSE_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### rtl/core/ksort_pkg.sv
// Shared types for the key sort engine.
`timescale 1ns / 1ps
`default_nettype none
package ksort_pkg;

	typedef struct packed {
		logic insert;
		logic shift;
		logic descending;
	} ksort_ctl_t;

endpackage
`default_nettype wire

### rtl/core/ksort_cell.sv
// One cell of the insertion chain: holds one key and its valid bit.
`timescale 1ns / 1ps
`default_nettype none
module ksort_cell #(
	parameter int KEY_WIDTH = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  ksort_pkg::ksort_ctl_t     ctl,
	input  wire  [KEY_WIDTH-1:0]      new_key,
	input  wire  [KEY_WIDTH-1:0]      prev_key,
	input  wire                       prev_valid,
	input  wire                       prev_gt,
	input  wire  [KEY_WIDTH-1:0]      next_key,
	input  wire                       next_valid,
	output logic [KEY_WIDTH-1:0]      cell_key,
	output logic                      cell_valid,
	output logic                      cell_gt
);
	import ksort_pkg::*;

	logic [KEY_WIDTH-1:0] key_q;
	logic                 valid_q;
	logic                 cmp;

	always_comb begin
		cmp     = ctl.descending ? (key_q < new_key) : (key_q > new_key);
		cell_gt = !valid_q || cmp;
	end

	assign cell_key   = key_q;
	assign cell_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (ctl.insert && cell_gt) begin
			valid_q <= prev_gt ? prev_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= next_key;
		end else if (ctl.insert && cell_gt) begin
			key_q <= prev_gt ? prev_key : new_key;
		end
	end

endmodule
`default_nettype wire

### rtl/core/key_sort_engine.sv
// Top level of the key sort engine: cell chain, load/unload control, result register.
//
// Usage: write the sort order on the cfg channel (cfg_data, cfg_valid/cfg_ready,
// ready is always high) while the block is idle; 0 ascending, 1 descending.
// Load a set by pulsing start with key and last_item; a key is taken at each
// edge where start is high and busy is low, one key per cycle while loading.
// Each key is placed in the cell chain in the cycle it arrives.
// Keys beyond MAX_ITEMS are dropped and flag truncated on every result of the set.
// The key marked last_item ends the set: busy rises and stays high until every held key
// is unloaded, and the chain shifts one key per cycle into the result register.
// Results appear on sorted_key with result_valid high for one cycle each,
// each registered from the chain head while busy is high; last_result marks the final one.
// The receiver cannot stall; results are strobed and must be taken as shown.
// Reset empties the chain, clears the count and truncation flag, and selects ascending.
`timescale 1ns / 1ps
`default_nettype none
`include "key_sort_engine_assert.svh"
module key_sort_engine #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_WIDTH = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_data,
	input  wire         start,
	output logic        busy,
	input  wire  [31:0] key,
	input  wire         last_item,
	output logic        result_valid,
	output logic [31:0] sorted_key,
	output logic        last_result,
	output logic        truncated
);
	import ksort_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic                 desc_q;
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;
	logic                 unload_q;
	logic                 accept;
	logic                 room;
	logic [KEY_WIDTH+31:0] key_ext;
	logic [KEY_WIDTH-1:0]  key_w;
	logic [KEY_WIDTH+31:0] head_ext;
	ksort_ctl_t           ctl;

	logic [KEY_WIDTH-1:0] ckey   [MAX_ITEMS];
	logic                 cvalid [MAX_ITEMS];
	logic                 cgt    [MAX_ITEMS];

	logic                 res_valid_q;
	logic [31:0]          res_key_q;
	logic                 res_last_q;
	logic                 res_trunc_q;

	assign cfg_ready = 1'b1;
	assign busy      = unload_q;
	assign accept    = start && !unload_q;
	assign room      = cnt_q < CW'(MAX_ITEMS);
	assign key_ext   = {{KEY_WIDTH{1'b0}}, key};
	assign key_w     = key_ext[KEY_WIDTH-1:0];
	assign head_ext  = {32'd0, ckey[0]};

	always_comb begin
		ctl.insert     = accept && room;
		ctl.shift      = unload_q;
		ctl.descending = desc_q;
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] p_key;
		logic                 p_valid;
		logic                 p_gt;
		logic [KEY_WIDTH-1:0] n_key;
		logic                 n_valid;

		if (i == 0) begin : g_head
			assign p_key   = '0;
			assign p_valid = 1'b0;
			assign p_gt    = 1'b0;
		end else begin : g_body
			assign p_key   = ckey[i-1];
			assign p_valid = cvalid[i-1];
			assign p_gt    = cgt[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign n_key   = '0;
			assign n_valid = 1'b0;
		end else begin : g_mid
			assign n_key   = ckey[i+1];
			assign n_valid = cvalid[i+1];
		end

		ksort_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_key   (key_w),
			.prev_key  (p_key),
			.prev_valid(p_valid),
			.prev_gt   (p_gt),
			.next_key  (n_key),
			.next_valid(n_valid),
			.cell_key  (ckey[i]),
			.cell_valid(cvalid[i]),
			.cell_gt   (cgt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			desc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			unload_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= unload_q;
			if (unload_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					unload_q <= 1'b0;
					ovf_q    <= 1'b0;
				end
			end else if (accept) begin
				if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (last_item) begin
					unload_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (unload_q) begin
			res_key_q   <= head_ext[31:0];
			res_last_q  <= (cnt_q == CW'(1));
			res_trunc_q <= ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign sorted_key   = res_key_q;
	assign last_result  = res_last_q && res_valid_q;
	assign truncated    = res_trunc_q;

	`KSE_ASSERT(a_unload_nonempty, unload_q |-> (cnt_q != '0), "unload with empty chain")
	`KSE_ASSERT(a_cnt_bound, cnt_q <= CW'(MAX_ITEMS), "key count above capacity")
	`KSE_ASSERT(a_result_from_unload, res_valid_q |-> $past(unload_q), "result without unload")
	`KSE_ASSERT(a_last_ends_run, last_result |-> !unload_q, "unload continues after last result")
	`KSE_ASSERT_NEXT(a_last_clears, unload_q && (cnt_q == CW'(1)), (cnt_q == '0) && !ovf_q, "set state not cleared")

endmodule
`default_nettype wire
